// ===== hdl/hsvrgb_pkg.sv =====
// Package for the HSV to RGB converter: item types, sector codes and the
// fixed-point constants of the channel scaling. No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int HueW   = 9;
  localparam int PctW   = 7;
  localparam int ChanW  = 8;
  localparam int FracW  = 6;
  localparam int KW     = 13;
  localparam int ProdW  = 20;
  localparam int BiasW  = 24;
  localparam int QuotW  = 18;
  localparam int RecipW = QuotW + 19;
  localparam int NumStages = 6;

  localparam logic [HueW-1:0]  HueWrap   = 9'd360;
  localparam logic [PctW-1:0]  PctMax    = 7'd100;
  localparam logic [FracW-1:0] SectorDeg = 6'd60;
  localparam logic [KW-1:0]    FullScale = 13'd6000;
  localparam logic [BiasW-1:0] ChanMul   = 24'd17;
  localparam logic [BiasW-1:0] RoundBias = 24'd20000;
  localparam int               BiasShift = 6;
  localparam logic [RecipW-1:0] RecipMul = 37'd429497;
  localparam int               RecipShift = 28;
  localparam logic [ChanW:0]   ChanMax   = 9'd255;

  typedef enum logic [2:0] {
    SecRedYellow     = 3'd0,
    SecYellowGreen   = 3'd1,
    SecGreenCyan     = 3'd2,
    SecCyanBlue      = 3'd3,
    SecBlueMagenta   = 3'd4,
    SecMagentaRed    = 3'd5
  } sector_t;

  typedef logic [NumStages-1:0] stage_en_t;

  typedef struct packed {
    logic [HueW-1:0] hue_deg;
    logic [PctW-1:0] sat_pct;
    logic [PctW-1:0] val_pct;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
  } rgb_out_t;

endpackage

// ===== hdl/hsvrgb_front.sv =====
// First two pipeline stages: input clamping, sector decode and the three
// level factors p, q and t. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; (
  input  logic             clk,
  input  stage_en_t        en,
  input  hsv_in_t          in_data,
  output sector_t          sector,
  output logic [PctW-1:0]  val,
  output logic [KW-1:0]    kp,
  output logic [KW-1:0]    kq,
  output logic [KW-1:0]    kt
);

  logic [HueW-1:0]  hue_c;
  logic [PctW-1:0]  sat_c, val_c;
  sector_t          sec_c;
  logic [HueW-1:0]  base_c;

  sector_t          sec0_r, sec0_nxt;
  logic [FracW-1:0] frac0_r, frac0_nxt;
  logic [PctW-1:0]  sat0_r, val0_r;

  sector_t          sec1_r;
  logic [PctW-1:0]  val1_r;
  logic [KW-1:0]    kp1_r, kp1_nxt, kq1_r, kq1_nxt, kt1_r, kt1_nxt;

  always_comb begin
    hue_c = (in_data.hue_deg >= HueWrap) ? '0 : in_data.hue_deg;
    sat_c = (in_data.sat_pct > PctMax) ? PctMax : in_data.sat_pct;
    val_c = (in_data.val_pct > PctMax) ? PctMax : in_data.val_pct;
    priority if (hue_c >= 9'd300) begin
      sec_c = SecMagentaRed;
      base_c = 9'd300;
    end else if (hue_c >= 9'd240) begin
      sec_c = SecBlueMagenta;
      base_c = 9'd240;
    end else if (hue_c >= 9'd180) begin
      sec_c = SecCyanBlue;
      base_c = 9'd180;
    end else if (hue_c >= 9'd120) begin
      sec_c = SecGreenCyan;
      base_c = 9'd120;
    end else if (hue_c >= 9'd60) begin
      sec_c = SecYellowGreen;
      base_c = 9'd60;
    end else begin
      sec_c = SecRedYellow;
      base_c = 9'd0;
    end
    sec0_nxt  = sec_c;
    frac0_nxt = FracW'(hue_c - base_c);
  end

  always_comb begin
    kp1_nxt = FullScale - KW'(KW'(SectorDeg) * KW'(sat0_r));
    kq1_nxt = FullScale - KW'(KW'(frac0_r) * KW'(sat0_r));
    kt1_nxt = FullScale - KW'(KW'(SectorDeg - frac0_r) * KW'(sat0_r));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec0_r  <= sec0_nxt;
      frac0_r <= frac0_nxt;
      sat0_r  <= sat_c;
      val0_r  <= val_c;
    end
    if (en[1]) begin
      sec1_r <= sec0_r;
      val1_r <= val0_r;
      kp1_r  <= kp1_nxt;
      kq1_r  <= kq1_nxt;
      kt1_r  <= kt1_nxt;
    end
  end

  assign sector = sec1_r;
  assign val    = val1_r;
  assign kp     = kp1_r;
  assign kq     = kq1_r;
  assign kt     = kt1_r;

endmodule

// ===== hdl/hsvrgb_scale.sv =====
// Three-stage channel scaler: round_half_up(v * k * 255 / 600000), done as
// a product, a biased scale and a reciprocal multiply. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_scale import hsvrgb_pkg::*; (
  input  logic              clk,
  input  stage_en_t         en,
  input  logic [PctW-1:0]   val,
  input  logic [KW-1:0]     k,
  output logic [ChanW-1:0]  chan
);

  logic [ProdW-1:0]  prod_r, prod_nxt;
  logic [QuotW-1:0]  quot_r, quot_nxt;
  logic [ChanW-1:0]  chan_r, chan_nxt;
  logic [BiasW-1:0]  biased;
  logic [RecipW-1:0] recip;
  logic [ChanW:0]    q_raw;

  always_comb begin
    prod_nxt = ProdW'(ProdW'(val) * ProdW'(k));
    biased   = BiasW'(BiasW'(prod_r) * ChanMul) + RoundBias;
    quot_nxt = biased[BiasShift +: QuotW];
    recip    = RecipW'(quot_r) * RecipMul;
    q_raw    = recip[RecipShift +: ChanW + 1];
    chan_nxt = (q_raw > ChanMax) ? ChanMax[ChanW-1:0] : q_raw[ChanW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod_r <= prod_nxt;
    end
    if (en[3]) begin
      quot_r <= quot_nxt;
    end
    if (en[4]) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

// ===== hdl/hsv_to_rgb_converter_unit.sv =====
// Top level of the HSV to RGB converter: valid bits, stall control, channel
// selection by sector. Uses hsvrgb_pkg, hsvrgb_front and hsvrgb_scale.
`timescale 1ns / 1ps

// The input channel takes one item (hue in degrees, saturation and value in
// percent) on in_valid and in_ready; the output channel delivers one item
// (8-bit red, green and blue) on out_valid and out_ready for every input.
// The block is a six-stage pipeline: a new item can be accepted in every
// cycle while the output is not stalled.
// The depth is set by the two multiplies of the channel scaler and the
// reciprocal divide by 625, each with its own register stage.
// Each stage holds its item until the next one is free, so a stall at the
// output fills empty stages first and then drops in_ready; no item is lost
// or repeated. Synchronous reset empties all stages and clears out_valid.

module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rgb_out_t out_data
);

  logic [NumStages-1:0] vld_r;
  logic [NumStages:0]   rdy;
  stage_en_t            en;

  sector_t          sec1;
  logic [PctW-1:0]  val1;
  logic [KW-1:0]    kp1, kq1, kt1;
  logic [ChanW-1:0] cv, cp, cq, ct;
  sector_t          sec2_r, sec3_r, sec4_r;
  rgb_out_t         out_r, out_nxt;

  always_comb begin
    rdy[NumStages] = out_ready;
    for (int i = NumStages - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    en = rdy[NumStages-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NumStages; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  hsvrgb_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .sector  (sec1),
    .val     (val1),
    .kp      (kp1),
    .kq      (kq1),
    .kt      (kt1)
  );

  hsvrgb_scale u_scale_v (.clk(clk), .en(en), .val(val1), .k(FullScale), .chan(cv));
  hsvrgb_scale u_scale_p (.clk(clk), .en(en), .val(val1), .k(kp1), .chan(cp));
  hsvrgb_scale u_scale_q (.clk(clk), .en(en), .val(val1), .k(kq1), .chan(cq));
  hsvrgb_scale u_scale_t (.clk(clk), .en(en), .val(val1), .k(kt1), .chan(ct));

  always_comb begin
    unique case (sec4_r)
      SecRedYellow:   out_nxt = '{red_out: cv, green_out: ct, blue_out: cp};
      SecYellowGreen: out_nxt = '{red_out: cq, green_out: cv, blue_out: cp};
      SecGreenCyan:   out_nxt = '{red_out: cp, green_out: cv, blue_out: ct};
      SecCyanBlue:    out_nxt = '{red_out: cp, green_out: cq, blue_out: cv};
      SecBlueMagenta: out_nxt = '{red_out: ct, green_out: cp, blue_out: cv};
      default:        out_nxt = '{red_out: cv, green_out: cp, blue_out: cq};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sec2_r <= sec1;
    end
    if (en[3]) begin
      sec3_r <= sec2_r;
    end
    if (en[4]) begin
      sec4_r <= sec3_r;
    end
    if (en[5]) begin
      out_r <= out_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NumStages-1];
  assign out_data  = out_r;

endmodule
